### rtl/core/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every rising clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// cond must never be seen at a rising clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/core/xpp_pkg.sv
// Types and constants of the parity propagator.
`default_nettype none
package xpp_pkg;

    localparam int DOM_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int IDX_OUT_W  = 6;
    localparam int CNT_OUT_W  = 2;
    localparam int VCOUNT_W   = 7;
    localparam int CFG_DATA_W = 7;

    typedef logic [STATUS_W-1:0]   t_status;
    typedef logic [DOM_W-1:0]      t_domain;
    typedef logic [IDX_OUT_W-1:0]  t_out_index;
    typedef logic [CNT_OUT_W-1:0]  t_count;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic                  t_cfg_idx;

    localparam t_status ST_WRITTEN    = 3'd0;
    localparam t_status ST_SKIPPED    = 3'd1;
    localparam t_status ST_CONSISTENT = 3'd2;
    localparam t_status ST_CONFLICT   = 3'd3;
    localparam t_status ST_FORCED     = 3'd4;

    localparam t_cfg_idx CFG_TARGET_PARITY = 1'b0;
    localparam t_cfg_idx CFG_VAR_COUNT     = 1'b1;

    localparam t_domain DOM_FREE  = 2'd3;
    localparam t_domain DOM_ZERO  = 2'd1;
    localparam t_domain DOM_ONE   = 2'd2;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

endpackage
`default_nettype wire

### rtl/core/xpp_ram.sv
// Generic RAM: one write port, one read port, registered read data.
`default_nettype none
module xpp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

### rtl/core/xor_parity_propagator.sv
// Top level of the parity propagator: control sequencer around the domain RAM.
//
// Keeps a two-bit domain per variable in a RAM and checks one XOR constraint
// over the first var_count of them. After reset a clearing pass writes "both
// values allowed" to every entry, during which no transaction is accepted
// (configuration writes still are). A propagate transaction first reduces
// both watches modulo the scan length in a bit-serial remainder unit, reads
// the two watched domains and, when the skip test fails, scans the RAM one
// variable per cycle through its single read port before a wrap-up. One
// transaction is in work at a time; the output register holds a finished
// result while the next transaction is taken.
`default_nettype none
`include "assert_macros.svh"
module xor_parity_propagator #(
    parameter int MAX_VARS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire xpp_pkg::t_cfg_idx    i_cfg_idx,
    input  wire xpp_pkg::t_cfg_data   i_cfg_data,
    // input channel
    input  wire logic                 i_valid,
    output      logic                 o_ready,
    input  wire logic                 i_kind,
    input  wire logic [5:0]           i_var_index,
    input  wire xpp_pkg::t_domain     i_domain,
    // output channel
    output      logic                 o_valid,
    input  wire logic                 i_ready,
    output      xpp_pkg::t_status     o_status,
    output      xpp_pkg::t_out_index  o_forced_index,
    output      logic                 o_forced_value,
    output      xpp_pkg::t_count      o_unbound_count
);
    import xpp_pkg::*;

    localparam int AW   = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int LW   = AW + 1;
    localparam int CNTW = $clog2(AW + 1);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_RDA  = 4'd3;
    localparam logic [3:0] S_RDB  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]          r_state, n_state;
    logic                r_target, n_target;
    logic [VCOUNT_W-1:0] r_var_count, n_var_count;
    logic [AW-1:0]       r_wf, n_wf, r_ws, n_ws;
    logic [AW-1:0]       r_sh_a, n_sh_a, r_sh_b, n_sh_b;
    logic [AW-1:0]       r_rem_a, n_rem_a, r_rem_b, n_rem_b;
    logic [CNTW-1:0]     r_bitcnt, n_bitcnt;
    logic                r_ua, n_ua;
    logic [AW-1:0]       r_addr, n_addr;
    logic [LW-1:0]       r_issued, n_issued;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pend_idx, n_pend_idx;
    logic                r_pend_last, n_pend_last;
    logic                r_lhs, n_lhs;
    t_count              r_active, n_active;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    t_status             r_res_status, n_res_status;
    t_out_index          r_res_fidx, n_res_fidx;
    logic                r_res_fval, n_res_fval;
    t_count              r_res_cnt, n_res_cnt;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    t_out_index          r_out_fidx, n_out_fidx;
    logic                r_out_fval, n_out_fval;
    t_count              r_out_cnt, n_out_cnt;

    logic [LW-1:0]       w_len;
    logic [LW-1:0]       w_tmp_a, w_tmp_b;
    logic [LW-1:0]       w_addr_inc;
    logic                w_stop;
    logic                w_fval;
    logic                w_mem_we;
    logic [AW-1:0]       w_mem_waddr;
    t_domain             w_mem_wdata;
    logic [AW-1:0]       w_mem_raddr;
    t_domain             w_mem_rdata;

    xpp_ram #(
        .WIDTH (DOM_W),
        .DEPTH (MAX_VARS)
    ) u_dom_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // effective scan length: zero acts as one, capped at the store size
    always_comb begin
        if (r_var_count == '0) begin
            w_len = LW'(1);
        end else if (32'(r_var_count) > 32'(MAX_VARS)) begin
            w_len = LW'(MAX_VARS);
        end else begin
            w_len = LW'(r_var_count);
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign w_fval  = r_lhs ^ r_target;

    always_comb begin
        n_state      = r_state;
        n_target     = r_target;
        n_var_count  = r_var_count;
        n_wf         = r_wf;
        n_ws         = r_ws;
        n_sh_a       = r_sh_a;
        n_sh_b       = r_sh_b;
        n_rem_a      = r_rem_a;
        n_rem_b      = r_rem_b;
        n_bitcnt     = r_bitcnt;
        n_ua         = r_ua;
        n_addr       = r_addr;
        n_issued     = r_issued;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_pend_last  = r_pend_last;
        n_lhs        = r_lhs;
        n_active     = r_active;
        n_clr_addr   = r_clr_addr;
        n_res_status = r_res_status;
        n_res_fidx   = r_res_fidx;
        n_res_fval   = r_res_fval;
        n_res_cnt    = r_res_cnt;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_fidx   = r_out_fidx;
        n_out_fval   = r_out_fval;
        n_out_cnt    = r_out_cnt;
        w_mem_we     = 1'b0;
        w_mem_waddr  = r_clr_addr;
        w_mem_wdata  = DOM_FREE;
        w_mem_raddr  = r_addr;
        w_stop       = 1'b0;
        w_tmp_a      = {r_rem_a, r_sh_a[AW-1]};
        w_tmp_b      = {r_rem_b, r_sh_b[AW-1]};
        w_addr_inc   = LW'(r_addr) + LW'(1);

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_PARITY: n_target    = i_cfg_data[0];
                CFG_VAR_COUNT:     n_var_count = i_cfg_data[VCOUNT_W-1:0];
                default:           n_target    = r_target;
            endcase
        end

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                w_mem_we   = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_VARS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_kind) begin
                        w_mem_we     = (32'(i_var_index) < 32'(MAX_VARS));
                        w_mem_waddr  = AW'(i_var_index);
                        w_mem_wdata  = i_domain;
                        n_res_status = ST_WRITTEN;
                        n_res_fidx   = '0;
                        n_res_fval   = 1'b0;
                        n_res_cnt    = '0;
                        n_state      = S_DONE;
                    end else begin
                        n_sh_a   = r_wf;
                        n_sh_b   = r_ws;
                        n_rem_a  = '0;
                        n_rem_b  = '0;
                        n_bitcnt = CNTW'(AW);
                        n_state  = S_MOD;
                    end
                end
            end
            S_MOD: begin
                // restoring remainder, one watch bit per cycle, MSB first
                if (w_tmp_a >= w_len) begin
                    w_tmp_a = w_tmp_a - w_len;
                end
                if (w_tmp_b >= w_len) begin
                    w_tmp_b = w_tmp_b - w_len;
                end
                n_rem_a  = w_tmp_a[AW-1:0];
                n_rem_b  = w_tmp_b[AW-1:0];
                n_sh_a   = r_sh_a << 1;
                n_sh_b   = r_sh_b << 1;
                n_bitcnt = r_bitcnt - CNTW'(1);
                if (r_bitcnt == CNTW'(1)) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                w_mem_raddr = r_rem_a;
                n_state     = S_RDB;
            end
            S_RDB: begin
                w_mem_raddr = r_rem_b;
                n_ua        = (w_mem_rdata == DOM_FREE);
                n_state     = S_CHK;
            end
            S_CHK: begin
                if ((r_rem_a != r_rem_b) && r_ua && (w_mem_rdata == DOM_FREE)) begin
                    n_res_status = ST_SKIPPED;
                    n_res_fidx   = '0;
                    n_res_fval   = 1'b0;
                    n_res_cnt    = '0;
                    n_state      = S_DONE;
                end else begin
                    n_addr   = r_rem_a;
                    n_issued = '0;
                    n_pend   = 1'b0;
                    n_lhs    = 1'b0;
                    n_active = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // data of the read issued last cycle
                if (r_pend) begin
                    if (!w_mem_rdata[0]) begin
                        n_lhs = ~r_lhs;
                    end else if (w_mem_rdata[1]) begin
                        if (r_active == '0) begin
                            n_active = CNT_OUT_W'(1);
                            n_wf     = r_pend_idx;
                        end else begin
                            n_active = CNT_OUT_W'(2);
                            n_ws     = r_pend_idx;
                            w_stop   = 1'b1;
                        end
                    end
                    if (r_pend_last) begin
                        w_stop = 1'b1;
                    end
                end
                if (w_stop) begin
                    n_pend  = 1'b0;
                    n_state = S_FIN;
                end else if (r_issued != w_len) begin
                    w_mem_raddr = r_addr;
                    n_pend      = 1'b1;
                    n_pend_idx  = r_addr;
                    n_pend_last = ((r_issued + LW'(1)) == w_len);
                    n_addr      = (w_addr_inc == w_len) ? '0 : w_addr_inc[AW-1:0];
                    n_issued    = r_issued + LW'(1);
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_FIN: begin
                n_res_fidx = '0;
                n_res_fval = 1'b0;
                n_res_cnt  = r_active;
                if (r_active == '0) begin
                    n_res_status = (r_lhs != r_target) ? ST_CONFLICT : ST_CONSISTENT;
                end else if (r_active == CNT_OUT_W'(1)) begin
                    w_mem_we     = 1'b1;
                    w_mem_waddr  = r_wf;
                    w_mem_wdata  = w_fval ? DOM_ONE : DOM_ZERO;
                    n_res_status = ST_FORCED;
                    n_res_fidx   = IDX_OUT_W'(r_wf);
                    n_res_fval   = w_fval;
                end else begin
                    n_res_status = ST_CONSISTENT;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_fidx   = r_res_fidx;
                    n_out_fval   = r_res_fval;
                    n_out_cnt    = r_res_cnt;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_target    <= 1'b0;
            r_var_count <= VCOUNT_RESET;
            r_wf        <= '0;
            r_ws        <= AW'(1);
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_active    <= '0;
            r_issued    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_target    <= n_target;
            r_var_count <= n_var_count;
            r_wf        <= n_wf;
            r_ws        <= n_ws;
            r_clr_addr  <= n_clr_addr;
            r_pend      <= n_pend;
            r_active    <= n_active;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh_a       <= n_sh_a;
        r_sh_b       <= n_sh_b;
        r_rem_a      <= n_rem_a;
        r_rem_b      <= n_rem_b;
        r_bitcnt     <= n_bitcnt;
        r_ua         <= n_ua;
        r_addr       <= n_addr;
        r_pend_idx   <= n_pend_idx;
        r_pend_last  <= n_pend_last;
        r_lhs        <= n_lhs;
        r_res_status <= n_res_status;
        r_res_fidx   <= n_res_fidx;
        r_res_fval   <= n_res_fval;
        r_res_cnt    <= n_res_cnt;
        r_out_status <= n_out_status;
        r_out_fidx   <= n_out_fidx;
        r_out_fval   <= n_out_fval;
        r_out_cnt    <= n_out_cnt;
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_forced_index  = r_out_fidx;
    assign o_forced_value  = r_out_fval;
    assign o_unbound_count = r_out_cnt;

    `ASSERT_AT(a_status_range, i_clk, i_rst_n, o_valid |-> (o_status <= ST_FORCED))
    `ASSERT_AT(a_unused_fields, i_clk, i_rst_n, (o_valid && (o_status != ST_FORCED)) |-> ((o_forced_index == '0) && !o_forced_value))
    `ASSERT_AT(a_no_count_on_write_skip, i_clk, i_rst_n, (o_valid && ((o_status == ST_WRITTEN) || (o_status == ST_SKIPPED))) |-> (o_unbound_count == '0))
    `ASSERT_AT(a_scan_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_issued <= w_len))
    `ASSERT_NEVER(a_write_in_scan, i_clk, i_rst_n, (r_state == S_SCAN) && w_mem_we)
    `ASSERT_NEVER(a_active_overflow, i_clk, i_rst_n, r_active == CNT_OUT_W'(3))
endmodule
`default_nettype wire
